// File: hw/rtl/bqeq_pkg.sv
package bqeq_pkg;

   localparam int BANDS    = 7;
   localparam int COEFS    = 5;
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 32;
   localparam int HIST_W   = 32;
   localparam int GAIN_W   = 16;
   localparam int COEF_N   = BANDS * COEFS;
   localparam int HIST_N   = 2 * BANDS * 4;
   localparam int COEF_AW  = $clog2(COEF_N);
   localparam int HIST_AW  = $clog2(HIST_N);
   localparam int BAND_W   = $clog2(BANDS + 1);
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = 44;
   localparam int WG_W     = 36;
   localparam int EXP_STEPS = 12;

   typedef enum logic [1:0] {
      ACT_FILTER = 2'd0,
      ACT_COEF   = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_RSVD   = 2'd3
   } action_type;

   localparam logic [1:0] CSR_EQ_ENABLE = 2'd0;
   localparam logic [1:0] CSR_GAIN      = 2'd1;
   localparam logic [1:0] CSR_BANDS     = 2'd2;

   // exp(-2^k) in Q.30 for k = 3 down to -8
   function automatic logic [29:0] exp_tab(input logic [3:0] idx);
      logic [29:0] v;
      case (idx)
         4'd0:    v = 30'd360200;
         4'd1:    v = 30'd19666267;
         4'd2:    v = 30'd145315154;
         4'd3:    v = 30'd395007542;
         4'd4:    v = 30'd651257337;
         4'd5:    v = 30'd836230973;
         4'd6:    v = 30'd947573834;
         4'd7:    v = 30'd1008687096;
         4'd8:    v = 30'd1040706261;
         4'd9:    v = 30'd1057095000;
         4'd10:   v = 30'd1065385899;
         4'd11:   v = 30'd1069551552;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/bqeq_mul.sv
module bqeq_mul import bqeq_pkg::*; (
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/biquad_cascade_equalizer.sv
// channel  | direction | handshake                | payload
// req      | in        | req_tvalid / req_tready  | tdata: band_sel, coef_sel, coef_value,
//          |           |                          | sample_in; tuser: action, channel; tlast
// rsp      | out       | rsp_tvalid / rsp_tready  | tdata: sample_out; tuser: channel_out; tlast
// csr      | in        | csr_we                   | csr_index, csr_wdata
//
// One request at a time. A filter request passes through idle, a band check before each band
// and after the last, for each enabled band the multiply-accumulate, saturate and history
// write-back steps, then gain multiply and round, clip, the optional soft clip and output.
// The shared multiplier and the one-read-port coefficient and history memories serialize this
// work. Coefficient write and clear requests finish in idle; a bypassed request goes to output.
// Reset is synchronous; history and coefficients come up cleared and identity through
// per-entry valid bits, with no clearing pass. A result held by rsp_tready stalls the next
// result at output; the next request is still taken, but no later one until it leaves.
module biquad_cascade_equalizer import bqeq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // band_sel[2:0], coef_sel[5:3], coef_value[37:6], sample_in[61:38]
   input  logic [2:0]  req_tuser,   // action[1:0], channel[2]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sample_out[23:0]
   output logic        rsp_tuser,   // channel_out[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SEC_CHK, ST_SEC_MAC, ST_SEC_SAT, ST_SEC_WB, ST_GAIN_MUL, ST_GAIN_RND,
      ST_CLIP, ST_EXP_BIT, ST_EXP_RND, ST_POLY_SQ, ST_POLY_SUM, ST_POLY_MUL, ST_POLY_RND,
      ST_FIN
   } state_type;

   localparam logic signed [COEF_W-1:0]   COEF_ONE = COEF_W'(64'sd1 <<< (COEF_W - 4));
   localparam logic signed [ACC_W-1:0]    H_MAX    = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0]    H_MIN    = -H_MAX - ACC_W'(1);
   localparam logic signed [WG_W-1:0]     W_ONE    = WG_W'(64'sd1 <<< (SAMPLE_W - 1));
   localparam logic signed [SAMPLE_W:0]   R_ONE    = (SAMPLE_W + 1)'(64'sd1 <<< (SAMPLE_W - 1));
   localparam logic signed [SAMPLE_W-1:0] S_MAX    = SAMPLE_W'(R_ONE - 1);

   // request fields
   action_type                 req_action;
   logic                       req_chan;
   logic [2:0]                 req_band;
   logic [2:0]                 req_csel;
   logic signed [COEF_W-1:0]   req_coef;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_fire;

   assign req_action = action_type'(req_tuser[1:0]);
   assign req_chan   = req_tuser[2];
   assign req_band   = req_tdata[2:0];
   assign req_csel   = req_tdata[5:3];
   assign req_coef   = req_tdata[37:6];
   assign req_sample = req_tdata[61:38];
   assign req_fire   = req_tvalid && req_tready;

   // configuration
   logic              eq_en_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [BANDS-1:0]  band_en_ff;

   // control and datapath
   state_type                  state_ff;
   logic [BAND_W-1:0]          band_ff;
   logic [2:0]                 step_ff;
   logic [3:0]                 bit_ff;
   logic                       ch_ff;
   logic                       last_ff;
   logic                       neg_ff;
   logic signed [HIST_W-1:0]   v_ff;
   logic signed [HIST_W-1:0]   y_ff;
   logic signed [HIST_W-1:0]   x1_ff;
   logic signed [HIST_W-1:0]   y1_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [WG_W-1:0]     w_ff;
   logic [26:0]                d_ff;
   logic [30:0]                e_ff;
   logic [30:0]                poly_ff;
   logic signed [SAMPLE_W-1:0] res_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_ch_ff;
   logic                       rsp_last_ff;

   assign req_tready = (state_ff == ST_IDLE);

   // memories
   logic signed [COEF_W-1:0] coef_mem [COEF_N];
   logic signed [HIST_W-1:0] hist_mem [HIST_N];
   logic [COEF_N-1:0]        coef_vld_ff;
   logic [HIST_N-1:0]        hist_vld_ff;
   logic signed [COEF_W-1:0] coef_q_ff;
   logic signed [HIST_W-1:0] hist_q_ff;
   logic                     coef_vq_ff;
   logic                     coef_b0q_ff;
   logic                     hist_vq_ff;

   logic                     coef_we;
   logic [COEF_AW-1:0]       coef_waddr;
   logic [2:0]               coef_k;
   logic [COEF_AW-1:0]       coef_raddr;
   logic [HIST_AW-3:0]       hist_row;
   logic [1:0]               hist_ridx;
   logic [HIST_AW-1:0]       hist_raddr;
   logic [HIST_AW-1:0]       hist_waddr;
   logic                     hist_we;
   logic signed [HIST_W-1:0] hist_wdata;
   logic                     hist_clr;
   logic signed [COEF_W-1:0] coef_rd;
   logic signed [HIST_W-1:0] hist_rd;

   assign coef_we    = req_fire && (req_action == ACT_COEF) && (req_band < BANDS)
                       && (req_csel < COEFS);
   assign coef_waddr = COEF_AW'(req_band * COEFS + req_csel);
   assign coef_k     = (step_ff < COEFS) ? step_ff : 3'd0;
   assign coef_raddr = COEF_AW'(band_ff * COEFS + coef_k);
   assign hist_row   = (HIST_AW - 2)'(ch_ff * BANDS + band_ff);
   assign hist_ridx  = 2'(step_ff - 3'd1);
   assign hist_raddr = {hist_row, hist_ridx};
   assign hist_waddr = {hist_row, step_ff[1:0]};
   assign hist_we    = (state_ff == ST_SEC_WB);
   assign hist_clr   = (req_fire && (req_action == ACT_CLEAR))
                       || (csr_we && (csr_index == CSR_EQ_ENABLE) && !csr_wdata[0]);

   always_comb begin
      case (step_ff[1:0])
         2'd0:    hist_wdata = v_ff;
         2'd1:    hist_wdata = x1_ff;
         2'd2:    hist_wdata = y_ff;
         default: hist_wdata = y1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_coef;
      end
      coef_q_ff   <= coef_mem[coef_raddr];
      coef_vq_ff  <= coef_vld_ff[coef_raddr];
      coef_b0q_ff <= (coef_k == 3'd0);
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q_ff  <= hist_mem[hist_raddr];
      hist_vq_ff <= hist_vld_ff[hist_raddr];
   end

   // an entry never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
      end else begin
         if (coef_we) begin
            coef_vld_ff[coef_waddr] <= 1'b1;
         end
         if (hist_clr) begin
            hist_vld_ff <= '0;
         end else if (hist_we) begin
            hist_vld_ff[hist_waddr] <= 1'b1;
         end
      end
   end

   assign coef_rd = coef_vq_ff ? coef_q_ff : (coef_b0q_ff ? COEF_ONE : '0);
   assign hist_rd = hist_vq_ff ? hist_q_ff : '0;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [21:0]              rem;

   assign rem = {d_ff[14:0], 7'd0};

   always_comb begin
      case (state_ff)
         ST_SEC_MAC: begin
            mul_a = MUL_W'(coef_rd);
            mul_b = (step_ff == 3'd1) ? MUL_W'(v_ff) : MUL_W'(hist_rd);
         end
         ST_GAIN_MUL: begin
            mul_a = MUL_W'(v_ff);
            mul_b = MUL_W'({1'b0, gain_ff});
         end
         ST_EXP_BIT: begin
            mul_a = MUL_W'({1'b0, e_ff});
            mul_b = MUL_W'({1'b0, exp_tab(bit_ff)});
         end
         ST_POLY_SQ: begin
            mul_a = MUL_W'({1'b0, rem});
            mul_b = MUL_W'({1'b0, rem});
         end
         ST_POLY_MUL: begin
            mul_a = MUL_W'({1'b0, e_ff});
            mul_b = MUL_W'({1'b0, poly_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   bqeq_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // datapath helpers
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [WG_W-1:0]   d_pos;
   logic signed [WG_W-1:0]   d_neg;
   logic signed [WG_W-1:0]   d_sel;
   logic [4:0]               d_idx;
   logic [31:0]              e_rnd;
   logic [31:0]              e_fin;
   logic signed [SAMPLE_W:0] clip_pos;
   logic signed [SAMPLE_W:0] clip_neg;
   logic                     in_empty;
   logic                     in_full;

   assign term     = ACC_W'(prod >>> 24);
   assign acc_rnd  = (acc_ff + ACC_W'(8)) >>> 4;
   assign d_pos    = w_ff - W_ONE;
   assign d_neg    = -w_ff - W_ONE;
   assign d_sel    = (w_ff > W_ONE) ? d_pos : d_neg;
   assign d_idx    = 5'(26 - bit_ff);
   assign e_rnd    = 32'((prod + PROD_W'(64'sd1 <<< 29)) >>> 30);
   assign e_fin    = (e_rnd + 32'd64) >> 7;
   assign clip_pos = R_ONE - (SAMPLE_W + 1)'(e_fin);
   assign clip_neg = -R_ONE + (SAMPLE_W + 1)'(e_fin);
   assign in_empty = !rsp_valid_ff || rsp_tready;
   assign in_full  = (d_sel[WG_W-1:27] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eq_en_ff     <= 1'b1;
         gain_ff      <= GAIN_W'(4096);
         band_en_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         band_ff      <= '0;
         step_ff      <= '0;
         bit_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_EQ_ENABLE: eq_en_ff   <= csr_wdata[0];
               CSR_GAIN:      gain_ff    <= csr_wdata;
               CSR_BANDS:     band_en_ff <= csr_wdata[BANDS-1:0];
               default:       ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_action == ACT_FILTER)) begin
                  ch_ff   <= req_chan;
                  last_ff <= req_tlast;
                  band_ff <= '0;
                  v_ff    <= HIST_W'(signed'({req_sample, 1'b0}));
                  res_ff  <= req_sample;
                  state_ff <= eq_en_ff ? ST_SEC_CHK : ST_FIN;
               end
            end
            ST_SEC_CHK: begin
               step_ff <= '0;
               if (band_ff == BAND_W'(BANDS)) begin
                  state_ff <= ST_GAIN_MUL;
               end else if (band_en_ff[band_ff]) begin
                  state_ff <= ST_SEC_MAC;
               end else begin
                  band_ff <= band_ff + 1'b1;
               end
            end
            ST_SEC_MAC: begin
               // each step issues a read; read data and product are registered before accumulating
               if (step_ff == 3'd2) begin
                  x1_ff <= hist_rd;
               end
               if (step_ff == 3'd4) begin
                  y1_ff <= hist_rd;
               end
               if (step_ff == 3'd2) begin
                  acc_ff <= term;
               end else if (step_ff == 3'd3 || step_ff == 3'd4) begin
                  acc_ff <= acc_ff + term;
               end else if (step_ff == 3'd5 || step_ff == 3'd6) begin
                  acc_ff <= acc_ff - term;
               end
               if (step_ff == 3'd6) begin
                  state_ff <= ST_SEC_SAT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SEC_SAT: begin
               if (acc_rnd > H_MAX) begin
                  y_ff <= HIST_W'(H_MAX);
               end else if (acc_rnd < H_MIN) begin
                  y_ff <= HIST_W'(H_MIN);
               end else begin
                  y_ff <= HIST_W'(acc_rnd);
               end
               step_ff  <= '0;
               state_ff <= ST_SEC_WB;
            end
            ST_SEC_WB: begin
               if (step_ff == 3'd3) begin
                  v_ff     <= y_ff;
                  band_ff  <= band_ff + 1'b1;
                  state_ff <= ST_SEC_CHK;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_GAIN_MUL: begin
               state_ff <= ST_GAIN_RND;
            end
            ST_GAIN_RND: begin
               w_ff     <= WG_W'((prod + PROD_W'(4096)) >>> 13);
               state_ff <= ST_CLIP;
            end
            ST_CLIP: begin
               neg_ff <= (w_ff < -W_ONE);
               d_ff   <= d_sel[26:0];
               e_ff   <= 31'(32'd1 << 30);
               bit_ff <= '0;
               if (w_ff > W_ONE || w_ff < -W_ONE) begin
                  if (in_full) begin
                     // overshoot of 16 or more: exp term is zero
                     res_ff   <= (w_ff > W_ONE) ? S_MAX : SAMPLE_W'(-R_ONE);
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_EXP_BIT;
                  end
               end else if (w_ff == W_ONE) begin
                  res_ff   <= S_MAX;
                  state_ff <= ST_FIN;
               end else begin
                  res_ff   <= SAMPLE_W'(w_ff);
                  state_ff <= ST_FIN;
               end
            end
            ST_EXP_BIT: begin
               if (bit_ff == 4'(EXP_STEPS)) begin
                  state_ff <= ST_POLY_SQ;
               end else if (d_ff[d_idx]) begin
                  state_ff <= ST_EXP_RND;
               end else begin
                  bit_ff <= bit_ff + 1'b1;
               end
            end
            ST_EXP_RND: begin
               e_ff     <= 31'(e_rnd);
               bit_ff   <= bit_ff + 1'b1;
               state_ff <= ST_EXP_BIT;
            end
            ST_POLY_SQ: begin
               state_ff <= ST_POLY_SUM;
            end
            ST_POLY_SUM: begin
               poly_ff  <= 31'((33'd1 << 30) - 33'(rem) + 33'(prod >>> 31));
               state_ff <= ST_POLY_MUL;
            end
            ST_POLY_MUL: begin
               state_ff <= ST_POLY_RND;
            end
            ST_POLY_RND: begin
               if (neg_ff) begin
                  res_ff <= SAMPLE_W'(clip_neg);
               end else if (clip_pos > (SAMPLE_W + 1)'(S_MAX)) begin
                  res_ff <= S_MAX;
               end else begin
                  res_ff <= SAMPLE_W'(clip_pos);
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               // hold until the output register is free
               if (in_empty) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  rsp_ch_ff    <= ch_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ch_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_bypass_direct: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_action == ACT_FILTER) && !eq_en_ff) |=> (state_ff == ST_FIN))
      else $error("bypassed request did not go straight to output");

   a_clear_hist: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_action == ACT_CLEAR)) |=> (hist_vld_ff == '0))
      else $error("history clear left valid entries");

   a_wb_band: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEC_WB) |-> (band_ff < BAND_W'(BANDS)))
      else $error("history write-back beyond last band");

   a_exp_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXP_RND) |-> (bit_ff < 4'(EXP_STEPS)))
      else $error("exp step past table");

endmodule
